>>> rtl/circ_pkg.sv
// ----------------------------------------------------------------------------
// Circumcircle package
// Shared widths, constants and item types for the circumcircle pipeline.
// ----------------------------------------------------------------------------
package circ_pkg;

  localparam int COORD_BITS           = 12;
  localparam int RADIUS_FRAC_BITS_DEF = 4;
  localparam int CENTER_FRAC          = 8;
  localparam int CENTER_W             = 16;
  localparam int RADIUS_W             = 28;

  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * COORD_BITS;
  localparam int SUMSQ_W  = SQ_W + 1;
  localparam int BB_W     = SUMSQ_W + 1;
  localparam int DPROD_W  = 2 * DIFF_W;
  localparam int DET_W    = DPROD_W + 1;
  localparam int NPROD_W  = BB_W + DIFF_W;
  localparam int NUM_W    = NPROD_W + 1;
  localparam int DEN_W    = DET_W;
  localparam int MAG_W    = NUM_W;
  localparam int QUO_W    = MAG_W + CENTER_FRAC;
  localparam int QW1      = QUO_W + 1;
  localparam int AX_W     = QUO_W + 2;

  localparam int SQRT_TOP_BIT = 36;
  localparam int HALF_W       = SQRT_TOP_BIT / 2;
  localparam int ROOT_W       = SQRT_TOP_BIT + 1;
  localparam int RAD_SQ_W     = 2 * ROOT_W;
  localparam int REM_W        = ROOT_W + 2;

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  typedef struct packed {
    logic [COORD_BITS-1:0] first_x;
    logic [COORD_BITS-1:0] first_y;
    logic [COORD_BITS-1:0] second_x;
    logic [COORD_BITS-1:0] second_y;
    logic [COORD_BITS-1:0] third_x;
    logic [COORD_BITS-1:0] third_y;
  } in_item_t;

  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0]        radius_fixed;
    logic                       degenerate;
  } out_item_t;

  typedef struct packed {
    logic                        deg;
    logic [1:0]                  neg;
    logic [DEN_W-1:0]            den;
    logic [1:0][COORD_BITS-1:0]  pnt;
  } div_side_t;

  typedef struct packed {
    logic                       deg;
    logic                       rsat;
    logic signed [CENTER_W-1:0] cx;
    logic signed [CENTER_W-1:0] cy;
  } sq_side_t;

endpackage

>>> rtl/circ_front.sv
// ----------------------------------------------------------------------------
// Circumcircle front end
// Four stages that form the determinant and the center numerators.
// ----------------------------------------------------------------------------
module circ_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  circ_pkg::in_item_t              in_data,
  output logic                            front_valid,
  output circ_pkg::div_side_t             front_side,
  output logic [circ_pkg::QUO_W-1:0]      front_num [2]
);
  import circ_pkg::*;

  logic [3:0] v_r;

  logic signed [DIFF_W-1:0] dx12_r, dy12_r, dx23_r, dy23_r;
  logic [SQ_W-1:0] sx1_r, sy1_r, sx2_r, sy2_r, sx3_r, sy3_r;
  logic [1:0][COORD_BITS-1:0] p1_r, p2_r, p3_r;

  logic [SUMSQ_W-1:0] s1, s2, s3;
  logic signed [DIFF_W-1:0] dx12b_r, dy12b_r, dx23b_r, dy23b_r;
  logic signed [DPROD_W-1:0] pa_r, pb_r;
  logic signed [BB_W-1:0] bb_r, cc_r;

  logic signed [DET_W-1:0] det_r;
  logic signed [NPROD_W-1:0] nxa_r, nxb_r, nya_r, nyb_r;

  logic signed [NUM_W-1:0] nx, ny;
  logic [MAG_W-1:0] xmag, ymag;
  logic [DET_W-1:0] dabs;
  div_side_t side_nxt;

  assign s1 = SUMSQ_W'(sx1_r) + SUMSQ_W'(sy1_r);
  assign s2 = SUMSQ_W'(sx2_r) + SUMSQ_W'(sy2_r);
  assign s3 = SUMSQ_W'(sx3_r) + SUMSQ_W'(sy3_r);

  assign nx = NUM_W'(nxa_r) - NUM_W'(nxb_r);
  assign ny = NUM_W'(nya_r) - NUM_W'(nyb_r);
  assign xmag = nx[NUM_W-1] ? $unsigned(-nx) : $unsigned(nx);
  assign ymag = ny[NUM_W-1] ? $unsigned(-ny) : $unsigned(ny);
  assign dabs = det_r[DET_W-1] ? $unsigned(-det_r) : $unsigned(det_r);

  always_comb begin
    side_nxt.deg    = (det_r == '0);
    side_nxt.neg[0] = nx[NUM_W-1] ^ det_r[DET_W-1];
    side_nxt.neg[1] = ny[NUM_W-1] ^ det_r[DET_W-1];
    side_nxt.den    = {dabs[DET_W-2:0], 1'b0};
    side_nxt.pnt    = p3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx12_r <= $signed({1'b0, in_data.first_x})  - $signed({1'b0, in_data.second_x});
      dy12_r <= $signed({1'b0, in_data.first_y})  - $signed({1'b0, in_data.second_y});
      dx23_r <= $signed({1'b0, in_data.second_x}) - $signed({1'b0, in_data.third_x});
      dy23_r <= $signed({1'b0, in_data.second_y}) - $signed({1'b0, in_data.third_y});
      sx1_r  <= SQ_W'(in_data.first_x)  * SQ_W'(in_data.first_x);
      sy1_r  <= SQ_W'(in_data.first_y)  * SQ_W'(in_data.first_y);
      sx2_r  <= SQ_W'(in_data.second_x) * SQ_W'(in_data.second_x);
      sy2_r  <= SQ_W'(in_data.second_y) * SQ_W'(in_data.second_y);
      sx3_r  <= SQ_W'(in_data.third_x)  * SQ_W'(in_data.third_x);
      sy3_r  <= SQ_W'(in_data.third_y)  * SQ_W'(in_data.third_y);
      p1_r   <= {in_data.second_y, in_data.second_x};

      pa_r    <= DPROD_W'(dx12_r) * DPROD_W'(dy23_r);
      pb_r    <= DPROD_W'(dx23_r) * DPROD_W'(dy12_r);
      bb_r    <= $signed({1'b0, s1}) - $signed({1'b0, s2});
      cc_r    <= $signed({1'b0, s2}) - $signed({1'b0, s3});
      dx12b_r <= dx12_r;
      dy12b_r <= dy12_r;
      dx23b_r <= dx23_r;
      dy23b_r <= dy23_r;
      p2_r    <= p1_r;

      det_r <= DET_W'(pa_r) - DET_W'(pb_r);
      nxa_r <= NPROD_W'(bb_r) * NPROD_W'(dy23b_r);
      nxb_r <= NPROD_W'(cc_r) * NPROD_W'(dy12b_r);
      nya_r <= NPROD_W'(cc_r) * NPROD_W'(dx12b_r);
      nyb_r <= NPROD_W'(bb_r) * NPROD_W'(dx23b_r);
      p3_r  <= p2_r;

      front_side   <= side_nxt;
      front_num[0] <= {xmag, CENTER_FRAC'(0)};
      front_num[1] <= {ymag, CENTER_FRAC'(0)};
    end
  end

  assign front_valid = v_r[3];

endmodule

>>> rtl/circ_div_cell.sv
// ----------------------------------------------------------------------------
// Circumcircle divider cell
// One restoring division step: one quotient bit per cell.
// ----------------------------------------------------------------------------
module circ_div_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [circ_pkg::DEN_W-1:0]  den,
  input  logic [circ_pkg::DEN_W-1:0]  rem_in,
  input  logic [circ_pkg::QUO_W-1:0]  nq_in,
  output logic [circ_pkg::DEN_W-1:0]  rem_out,
  output logic [circ_pkg::QUO_W-1:0]  nq_out
);
  import circ_pkg::*;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [QUO_W-1:0] nq_r, nq_nxt;

  assign trial   = {rem_in, nq_in[QUO_W-1]};
  assign ge      = (trial >= {1'b0, den});
  assign diff    = trial - {1'b0, den};
  assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  assign nq_nxt  = {nq_in[QUO_W-2:0], ge};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      nq_r  <= nq_nxt;
    end
  end

  assign rem_out = rem_r;
  assign nq_out  = nq_r;

endmodule

>>> rtl/circ_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Circumcircle square root cell
// One digit-by-digit square root step: one root bit per cell.
// ----------------------------------------------------------------------------
module circ_sqrt_cell (
  input  logic                           clk,
  input  logic                           en,
  input  logic [circ_pkg::RAD_SQ_W-1:0]  rad_in,
  input  logic [circ_pkg::REM_W-1:0]     rem_in,
  input  logic [circ_pkg::ROOT_W-1:0]    root_in,
  output logic [circ_pkg::RAD_SQ_W-1:0]  rad_out,
  output logic [circ_pkg::REM_W-1:0]     rem_out,
  output logic [circ_pkg::ROOT_W-1:0]    root_out
);
  import circ_pkg::*;

  logic [REM_W+1:0]    part;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    diff;
  logic                ge;
  logic [RAD_SQ_W-1:0] rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;

  assign part  = {rem_in, rad_in[RAD_SQ_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_in, 2'b01});
  assign ge    = (part >= trial);
  assign diff  = part - trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_in[RAD_SQ_W-3:0], 2'b00};
      rem_r  <= ge ? diff[REM_W-1:0] : part[REM_W-1:0];
      root_r <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign rad_out  = rad_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;

endmodule

>>> rtl/circumcircle_from_three_points.sv
// An accepted item passes through 4 front stages, a 48-cell divider chain,
// 5 rounding and squaring stages and a 37-cell square root chain to the
// output register.
// Throughput: one item per cycle, the cell chains included, while the skid is empty.
// A skid register holds one result while the output stalls; in_ready is registered.
// Reset (synchronous, active low) empties the pipeline and both output registers.
// ----------------------------------------------------------------------------
// Circumcircle from three points
// Pipelined circle through three pixel points, with center and radius.
// ----------------------------------------------------------------------------
module circumcircle_from_three_points #(
  parameter int RADIUS_FRAC_BITS = circ_pkg::RADIUS_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  circ_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output circ_pkg::out_item_t out_data
);
  import circ_pkg::*;

  localparam int SHIFT = CENTER_FRAC - RADIUS_FRAC_BITS;
  localparam int POST  = 5;

  logic en;
  logic front_valid;
  div_side_t front_side;
  logic [QUO_W-1:0] front_num [2];

  logic [QUO_W-1:0] dv_r;
  div_side_t dside_r [QUO_W];
  wire [DEN_W-1:0] drem [2][QUO_W];
  wire [QUO_W-1:0] dnq  [2][QUO_W];

  logic [POST-1:0] pv_r;
  logic signed [QW1-1:0] q1_r [2];
  logic [DEN_W-1:0] r1_r [2];
  div_side_t side1_r;

  logic signed [QW1-1:0] q8_r [2];
  logic signed [CENTER_W-1:0] c2_r [2];
  logic [1:0][COORD_BITS-1:0] pnt2_r;
  logic deg2_r;

  logic [SQRT_TOP_BIT-1:0] ax3_r [2];
  sq_side_t side3_r;
  logic [2*HALF_W-1:0] phh_r [2];
  logic [2*HALF_W-1:0] phl_r [2];
  logic [2*HALF_W-1:0] pll_r [2];
  sq_side_t side4_r;
  logic [RAD_SQ_W-1:0] rad5_r;
  sq_side_t side5_r;

  logic [ROOT_W-1:0] sv_r;
  sq_side_t sside_r [ROOT_W];
  wire [RAD_SQ_W-1:0] srad  [ROOT_W];
  wire [REM_W-1:0]    srem  [ROOT_W];
  wire [ROOT_W-1:0]   sroot [ROOT_W];

  logic out_valid_r, skid_v_r;
  out_item_t out_data_r, skid_r, res;
  logic take;

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign take     = out_valid_r && out_ready;

  circ_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .front_valid (front_valid),
    .front_side  (front_side),
    .front_num   (front_num)
  );

  for (genvar l = 0; l < 2; l++) begin : g_dlane
    for (genvar k = 0; k < QUO_W; k++) begin : g_dcell
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] nq_in;
      logic [DEN_W-1:0] den_in;
      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign nq_in  = front_num[l];
        assign den_in = front_side.den;
      end else begin : g_next
        assign rem_in = drem[l][k-1];
        assign nq_in  = dnq[l][k-1];
        assign den_in = dside_r[k-1].den;
      end
      circ_div_cell u_cell (
        .clk     (clk),
        .en      (en),
        .den     (den_in),
        .rem_in  (rem_in),
        .nq_in   (nq_in),
        .rem_out (drem[l][k]),
        .nq_out  (dnq[l][k])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= front_side;
      for (int k = 1; k < QUO_W; k++) begin
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  // Sign fixup of the magnitude division into a floor quotient and remainder.
  logic signed [QW1-1:0] qs [2];
  logic rnz [2];
  div_side_t dlast;
  assign dlast = dside_r[QUO_W-1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qs[l]  = $signed({1'b0, dnq[l][QUO_W-1]});
      rnz[l] = (drem[l][QUO_W-1] != '0);
    end
  end

  // Rounding to nearest, ties to even, at 8 fraction bits and at integer; the integer center then saturates to 16 bits.
  logic [DEN_W:0] two_r [2];
  logic gt8 [2], eq8 [2], up0 [2];
  logic signed [QW1-1:0] fl [2], cw [2];
  logic signed [QW1-1:0] q8n [2];
  logic [CENTER_FRAC-1:0] frac [2];
  logic signed [CENTER_W-1:0] csat [2];
  localparam logic [CENTER_FRAC-1:0] HALF_FRAC = CENTER_FRAC'(1) << (CENTER_FRAC - 1);

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      two_r[l] = {r1_r[l], 1'b0};
      gt8[l]   = two_r[l] > {1'b0, side1_r.den};
      eq8[l]   = two_r[l] == {1'b0, side1_r.den};
      q8n[l]   = q1_r[l] + $signed({{QUO_W{1'b0}}, gt8[l] || (eq8[l] && q1_r[l][0])});
      fl[l]    = q1_r[l] >>> CENTER_FRAC;
      frac[l]  = q1_r[l][CENTER_FRAC-1:0];
      up0[l]   = (frac[l] > HALF_FRAC) ||
                 ((frac[l] == HALF_FRAC) && ((r1_r[l] != '0) || fl[l][0]));
      cw[l]    = fl[l] + $signed({{QUO_W{1'b0}}, up0[l]});
      if ((&cw[l][QW1-1:CENTER_W-1]) || !(|cw[l][QW1-1:CENTER_W-1])) begin
        csat[l] = cw[l][CENTER_W-1:0];
      end else begin
        csat[l] = cw[l][QW1-1] ? {1'b1, {(CENTER_W-1){1'b0}}} : {1'b0, {(CENTER_W-1){1'b1}}};
      end
    end
  end

  logic signed [AX_W-1:0] adiff [2];
  logic [AX_W-1:0] aabs [2];
  logic big_a;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      adiff[l] = $signed(AX_W'({pnt2_r[l], CENTER_FRAC'(0)})) - AX_W'(q8_r[l]);
      aabs[l]  = adiff[l][AX_W-1] ? $unsigned(-adiff[l]) : $unsigned(adiff[l]);
    end
    big_a = (|aabs[0][AX_W-1:SQRT_TOP_BIT]) || (|aabs[1][AX_W-1:SQRT_TOP_BIT]);
  end

  logic [RAD_SQ_W-1:0] rad_sum;
  always_comb begin
    rad_sum = '0;
    for (int l = 0; l < 2; l++) begin
      rad_sum = rad_sum + (RAD_SQ_W'(phh_r[l]) << (2 * HALF_W))
                        + (RAD_SQ_W'(phl_r[l]) << (HALF_W + 1))
                        + RAD_SQ_W'(pll_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        q1_r[l] <= dlast.neg[l] ? (rnz[l] ? ~qs[l] : -qs[l]) : qs[l];
        r1_r[l] <= (dlast.neg[l] && rnz[l]) ? dlast.den - drem[l][QUO_W-1]
                                            : drem[l][QUO_W-1];
        q8_r[l] <= q8n[l];
        c2_r[l] <= csat[l];
        ax3_r[l] <= aabs[l][SQRT_TOP_BIT-1:0];
        phh_r[l] <= ax3_r[l][2*HALF_W-1:HALF_W] * ax3_r[l][2*HALF_W-1:HALF_W];
        phl_r[l] <= ax3_r[l][2*HALF_W-1:HALF_W] * ax3_r[l][HALF_W-1:0];
        pll_r[l] <= ax3_r[l][HALF_W-1:0] * ax3_r[l][HALF_W-1:0];
      end
      side1_r      <= dlast;
      pnt2_r       <= side1_r.pnt;
      deg2_r       <= side1_r.deg;
      side3_r.deg  <= deg2_r;
      side3_r.rsat <= big_a;
      side3_r.cx   <= c2_r[0];
      side3_r.cy   <= c2_r[1];
      side4_r      <= side3_r;
      rad5_r       <= rad_sum;
      side5_r      <= side4_r;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_scell
    logic [RAD_SQ_W-1:0] rad_in;
    logic [REM_W-1:0]    rem_in;
    logic [ROOT_W-1:0]   root_in;
    if (k == 0) begin : g_first
      assign rad_in  = rad5_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = srad[k-1];
      assign rem_in  = srem[k-1];
      assign root_in = sroot[k-1];
    end
    circ_sqrt_cell u_cell (
      .clk      (clk),
      .en       (en),
      .rad_in   (rad_in),
      .rem_in   (rem_in),
      .root_in  (root_in),
      .rad_out  (srad[k]),
      .rem_out  (srem[k]),
      .root_out (sroot[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sside_r[0] <= side5_r;
      for (int k = 1; k < ROOT_W; k++) begin
        sside_r[k] <= sside_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      pv_r <= '0;
      sv_r <= '0;
    end else if (en) begin
      dv_r <= {dv_r[QUO_W-2:0], front_valid};
      pv_r <= {pv_r[POST-2:0], dv_r[QUO_W-1]};
      sv_r <= {sv_r[ROOT_W-2:0], pv_r[POST-1]};
    end
  end

  logic [ROOT_W-1:0] rshift;
  sq_side_t slast;
  assign slast  = sside_r[ROOT_W-1];
  assign rshift = sroot[ROOT_W-1] >> SHIFT;

  always_comb begin
    res = '0;
    if (slast.deg) begin
      res.degenerate = 1'b1;
    end else begin
      res.center_x = slast.cx;
      res.center_y = slast.cy;
      if (slast.rsat || (|rshift[ROOT_W-1:RADIUS_W])) begin
        res.radius_fixed = RADIUS_MAX;
      end else begin
        res.radius_fixed = rshift[RADIUS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (skid_v_r) begin
      if (take) begin
        out_data_r <= skid_r;
        skid_v_r   <= 1'b0;
      end
    end else if (sv_r[ROOT_W-1]) begin
      if (!out_valid_r || out_ready) begin
        out_data_r  <= res;
        out_valid_r <= 1'b1;
      end else begin
        skid_r   <= res;
        skid_v_r <= 1'b1;
      end
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/circ_checker.sv
// ----------------------------------------------------------------------------
// Circumcircle port checker
// Port-level properties of the circumcircle block, bound to the top level.
// ----------------------------------------------------------------------------
module circ_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input circ_pkg::out_item_t out_data
);
  import circ_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result item changed or dropped while stalled.");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.center_x == '0 && out_data.center_y == '0 && out_data.radius_fixed == '0)
    else $error("Collinear item carries a nonzero center or radius.");

  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("Input stalled while no result item is waiting.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("Input stalled without a stalled result item.");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("Reset did not empty the block.");

endmodule

bind circumcircle_from_three_points circ_checker u_circ_checker (.*);

>>> tb/sv/circ_scoreboard.sv
// ----------------------------------------------------------------------------
// Circumcircle scoreboard
// Predicts the circle for each accepted point triple and checks each result
// against the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
class circ_scoreboard;
  circ_pkg::out_item_t pending[$];
  int errors;

  function new();
    pending = {};
    errors = 0;
  endfunction

  static function longint div_even(longint n, longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    if (r < 0) begin
      q--;
      r += d;
    end
    if (2 * r > d || (2 * r == d && q[0])) q++;
    return q;
  endfunction

  static function longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  static function circ_pkg::out_item_t circle_of(circ_pkg::in_item_t p);
    circ_pkg::out_item_t r;
    longint x1, y1, x2, y2, x3, y3, det, bb, cc, nx, ny, d, cx8, cy8;
    longint unsigned ax, ay, root, cand, rad;
    bit [127:0] s;
    x1 = p.first_x;  y1 = p.first_y;
    x2 = p.second_x; y2 = p.second_y;
    x3 = p.third_x;  y3 = p.third_y;
    r = '0;
    det = (x1 - x2) * (y2 - y3) - (x2 - x3) * (y1 - y2);
    if (det == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    bb = x1 * x1 + y1 * y1 - x2 * x2 - y2 * y2;
    cc = x2 * x2 + y2 * y2 - x3 * x3 - y3 * y3;
    nx = bb * (y2 - y3) - cc * (y1 - y2);
    ny = cc * (x1 - x2) - bb * (x2 - x3);
    d = 2 * det;
    if (d < 0) begin
      d = -d; nx = -nx; ny = -ny;
    end
    r.center_x = 16'(clamp16(div_even(nx, d)));
    r.center_y = 16'(clamp16(div_even(ny, d)));
    cx8 = div_even(nx * 256, d);
    cy8 = div_even(ny * 256, d);
    ax = (x2 * 256 - cx8 < 0) ? cx8 - x2 * 256 : x2 * 256 - cx8;
    ay = (y2 * 256 - cy8 < 0) ? cy8 - y2 * 256 : y2 * 256 - cy8;
    if (ax >= 64'd1 << 36 || ay >= 64'd1 << 36) begin
      rad = circ_pkg::RADIUS_MAX;
    end else begin
      s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay);
      root = 0;
      for (int b = 36; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (128'(cand) * 128'(cand) <= s) root = cand;
      end
      rad = root >> (circ_pkg::CENTER_FRAC - circ_pkg::RADIUS_FRAC_BITS_DEF);
      if (rad > circ_pkg::RADIUS_MAX) rad = circ_pkg::RADIUS_MAX;
    end
    r.radius_fixed = rad[27:0];
    return r;
  endfunction

  function void note_input(circ_pkg::in_item_t p);
    pending.insert(pending.size(), circle_of(p));
  endfunction

  function void check_result(circ_pkg::out_item_t got);
    circ_pkg::out_item_t want;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
        got.radius_fixed !== want.radius_fixed || got.degenerate !== want.degenerate) begin
      errors++;
      if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Circumcircle testbench
// Drives directed and random point triples through the pipeline with random
// stalls on both sides and checks every circle against a scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  circ_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  circ_pkg::out_item_t out_data;

  int send_idle = 27;
  int recv_idle = 48;
  int quiet_cycles = 0;
  circ_scoreboard board = new();

  circumcircle_from_three_points dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("DONE: errors detected");
        $finish;
      end
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_triple(input circ_pkg::in_item_t p);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [11:0] rand_coord();
    case ($urandom_range(5))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(15));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic circ_pkg::in_item_t random_triple();
    circ_pkg::in_item_t p;
    int k;
    p = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    k = $urandom_range(9);
    if (k == 0) begin
      p.third_x = p.first_x;
      p.third_y = p.first_y;
    end else if (k == 1) begin
      p.second_x = p.first_x + 12'($urandom_range(3));
      p.second_y = p.first_y + 12'($urandom_range(1));
      p.third_x = p.first_x + 12'($urandom_range(7));
      p.third_y = p.first_y + 12'($urandom_range(1));
    end
    return p;
  endfunction

  initial begin
    circ_pkg::in_item_t directed[$];
    directed.insert(directed.size(), '0);
    directed.insert(directed.size(), '1);
    directed.insert(directed.size(), {12'd0, 12'd0, 12'd1, 12'd0, 12'd0, 12'd1});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'hFFF, 12'd0, 12'd0, 12'hFFF});
    directed.insert(directed.size(), {12'hFFF, 12'hFFF, 12'd0, 12'hFFF, 12'hFFF, 12'd0});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'd1, 12'd1, 12'd2, 12'd2});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'hFFF, 12'hFFF, 12'd1, 12'd1});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'hFFF, 12'd1, 12'hFFE, 12'd0});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'hFFF, 12'd0, 12'hFFE, 12'd1});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'd2048, 12'd1, 12'hFFF, 12'd0});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'd1, 12'd1, 12'd2, 12'd0});
    directed.insert(directed.size(), {12'd0, 12'd0, 12'd3, 12'd1, 12'd2, 12'd0});
    directed.insert(directed.size(), {12'd5, 12'd5, 12'd5, 12'd5, 12'd9, 12'd1});
    directed.insert(directed.size(), {12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h123, 12'hEDC});
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_triple(directed[i]);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 48 : 0;
      recv_idle = (phase == 0) ? 48 : (phase == 1) ? 27 : 0;
      repeat (480) send_triple(random_triple());
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> circumcircle_from_three_points.f
rtl/circ_pkg.sv
rtl/circ_front.sv
rtl/circ_div_cell.sv
rtl/circ_sqrt_cell.sv
rtl/circumcircle_from_three_points.sv
rtl/circ_checker.sv
tb/sv/circ_scoreboard.sv
tb/sv/testbench.sv
